FILE: src/ffha_pkg.sv
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int WORD_W   = 64;
   localparam int ADDR_W   = 48;
   localparam int STATUS_W = 3;
   localparam int LIMIT_W  = 16;

   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK          = 3'd0;
   localparam status_type STATUS_BAD_SIZE    = 3'd1;
   localparam status_type STATUS_OUT_OF_MEM  = 3'd2;
   localparam status_type STATUS_NOT_IN_HEAP = 3'd3;
   localparam status_type STATUS_UNALIGNED   = 3'd4;
   localparam status_type STATUS_DOUBLE_FREE = 3'd5;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic CSR_HEAP_BASE  = 1'b0;
   localparam logic CSR_HEAP_LIMIT = 1'b1;

   localparam int               LINK_VALID_BIT = 63;
   localparam int               LINK_W         = 32;
   localparam int               HDR_BYTES      = 16;
   localparam int               MIN_SPARE      = 16;
   localparam int               MIN_ALIGN_LOG2 = 3;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd32768;

endpackage

FILE: src/ffha_arena_mem.sv
`timescale 1ns / 1ps

module ffha_arena_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ffha_pkg::word_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output ffha_pkg::word_type  rd_data
);

   ffha_pkg::word_type mem [DEPTH];
   ffha_pkg::word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// a rejected request is answered straight from the START state; a walk reads and
// evaluates each header in turn, a free walks back over the previous links to merge,
// growth maps one page at a time, and the header updates close the transaction
// one transaction at a time, a new start is taken in the rsp_valid cycle
// reset: a clearing pass over all ARENA_WORDS words rebuilds the arena, busy stays high meanwhile
// results are strobed for one cycle on rsp_valid; the receiver cannot stall

module first_fit_heap_allocator #(
   parameter int ARENA_WORDS = 4096,
   parameter int PAGE_BYTES  = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_func,
   input  logic [15:0]            req_request_bytes,
   input  logic [3:0]             req_align_log2,
   input  logic                   req_round_size,
   input  logic [47:0]            req_free_address,
   output logic                   rsp_valid,
   output logic [47:0]            rsp_payload_address,
   output ffha_pkg::status_type   rsp_status,
   input  logic                   csr_write_enable,
   input  logic                   csr_index,
   input  logic [47:0]            csr_write_data
);

   localparam int AW      = $clog2(ARENA_WORDS);
   localparam int AB_BITS = AW + 3;
   localparam int OW      = ((AB_BITS > 16) ? AB_BITS : 16) + 2;
   localparam logic [63:0] ARENA_BYTES = 64'(ARENA_WORDS) * 64'd8;
   localparam logic [OW-1:0] ARENA_LIM = OW'(ARENA_BYTES);
   localparam logic [63:0] FIRST_BYTES =
      (64'(PAGE_BYTES) < ARENA_BYTES) ? 64'(PAGE_BYTES) : ARENA_BYTES;
   localparam logic [63:0] INIT_WORD = 64'd0 - (FIRST_BYTES - 64'd32);
   localparam logic [OW-1:0] PAGE_O  = OW'(PAGE_BYTES);
   localparam logic [OW-1:0] HDR_O   = OW'(ffha_pkg::HDR_BYTES);
   localparam logic [OW-1:0] SPARE_O = OW'(ffha_pkg::HDR_BYTES + ffha_pkg::MIN_SPARE);
   localparam logic [OW-1:0] WORDS_O = OW'(ARENA_WORDS);
   localparam logic [AW-1:0] LAST_IDX = AW'(ARENA_WORDS - 1);

   localparam logic [4:0] ST_CLEAR  = 5'd0;
   localparam logic [4:0] ST_IDLE   = 5'd1;
   localparam logic [4:0] ST_START  = 5'd2;
   localparam logic [4:0] ST_A_RD   = 5'd3;
   localparam logic [4:0] ST_A_DAT  = 5'd4;
   localparam logic [4:0] ST_A_EVAL = 5'd5;
   localparam logic [4:0] ST_S_W0   = 5'd6;
   localparam logic [4:0] ST_S_W1   = 5'd7;
   localparam logic [4:0] ST_S_W2   = 5'd8;
   localparam logic [4:0] ST_S_W3   = 5'd9;
   localparam logic [4:0] ST_P_RD   = 5'd10;
   localparam logic [4:0] ST_P_DAT  = 5'd11;
   localparam logic [4:0] ST_P_EVAL = 5'd12;
   localparam logic [4:0] ST_P_CHK  = 5'd13;
   localparam logic [4:0] ST_P_GROW = 5'd14;
   localparam logic [4:0] ST_P_W0   = 5'd15;
   localparam logic [4:0] ST_P_W1   = 5'd16;
   localparam logic [4:0] ST_P_W2   = 5'd17;
   localparam logic [4:0] ST_F_RD   = 5'd18;
   localparam logic [4:0] ST_F_DAT  = 5'd19;
   localparam logic [4:0] ST_F_EVAL = 5'd20;
   localparam logic [4:0] ST_B_RD   = 5'd21;
   localparam logic [4:0] ST_B_DAT  = 5'd22;
   localparam logic [4:0] ST_B_PRD  = 5'd23;
   localparam logic [4:0] ST_B_PDAT = 5'd24;
   localparam logic [4:0] ST_C_RD   = 5'd25;
   localparam logic [4:0] ST_C_DAT  = 5'd26;
   localparam logic [4:0] ST_C_EVAL = 5'd27;
   localparam logic [4:0] ST_M_W0   = 5'd28;
   localparam logic [4:0] ST_M_W1   = 5'd29;

   function automatic ffha_pkg::word_type neg_word(input logic [OW-1:0] m);
      return 64'd0 - 64'(m);
   endfunction

   function automatic ffha_pkg::word_type link_word(input logic [OW-1:0] p);
      return (64'd1 << ffha_pkg::LINK_VALID_BIT) | 64'(p);
   endfunction

   function automatic logic [OW-1:0] size_idx(input logic [OW-1:0] o);
      return (o >> 3) + OW'(1);
   endfunction

   // control registers
   logic [4:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [OW-1:0] last_ff, last_in;
   logic [OW-1:0] mapped_ff, mapped_in;
   logic [47:0]   base_ff, base_in;
   logic [15:0]   limit_ff, limit_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // transaction registers
   logic          func_ff, func_in;
   logic [15:0]   req_ff, req_in;
   logic          rnd_ff, rnd_in;
   logic [15:0]   amask_ff, amask_in;
   logic [16:0]   size_ff, size_in;
   logic [47:0]   faddr_ff, faddr_in;
   logic [OW-1:0] end_ff, end_in;
   logic [OW-1:0] o_ff, o_in;
   logic [OW-1:0] off_ff, off_in;
   logic [OW-1:0] ns_ff, ns_in;
   logic [OW-1:0] hm_ff, hm_in;
   logic          hf_ff, hf_in;
   logic [OW-1:0] n_ff, n_in;
   logic [OW-1:0] pad_ff, pad_in;
   logic [OW-1:0] stop_ff, stop_in;
   logic [OW-1:0] newmap_ff, newmap_in;
   logic          oor_ff, oor_in;
   logic [47:0]   rsp_addr_ff, rsp_addr_in;
   ffha_pkg::status_type rsp_status_ff, rsp_status_in;

   // memory access
   logic               rd_req, wr_req;
   logic [OW-1:0]      rd_idx, wr_idx;
   ffha_pkg::word_type wr_val;
   logic               mem_re, mem_we;
   ffha_pkg::word_type mem_rdata;
   ffha_pkg::word_type wd;
   ffha_pkg::word_type mg64;
   logic [OW-1:0]      dmag;

   // scratch
   logic [3:0]    al_eff;
   logic [15:0]   alow, plow, pad16;
   logic [OW-1:0] n0, stop_v;
   logic [48:0]   lo_bound;
   logic [47:0]   off48;
   logic [31:0]   pbv;

   assign wd   = oor_ff ? '0 : mem_rdata;
   assign mg64 = wd[63] ? (64'd0 - wd) : wd;
   assign dmag = (mg64 > ARENA_BYTES) ? ARENA_LIM : mg64[OW-1:0];

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      last_in       = last_ff;
      mapped_in     = mapped_ff;
      base_in       = base_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = 1'b0;
      func_in       = func_ff;
      req_in        = req_ff;
      rnd_in        = rnd_ff;
      amask_in      = amask_ff;
      size_in       = size_ff;
      faddr_in      = faddr_ff;
      end_in        = end_ff;
      o_in          = o_ff;
      off_in        = off_ff;
      ns_in         = ns_ff;
      hm_in         = hm_ff;
      hf_in         = hf_ff;
      n_in          = n_ff;
      pad_in        = pad_ff;
      stop_in       = stop_ff;
      newmap_in     = newmap_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rd_req        = 1'b0;
      rd_idx        = '0;
      wr_req        = 1'b0;
      wr_idx        = '0;
      wr_val        = '0;

      al_eff   = (req_align_log2 < 4'(ffha_pkg::MIN_ALIGN_LOG2)) ?
                 4'(ffha_pkg::MIN_ALIGN_LOG2) : req_align_log2;
      alow     = base_ff[15:0] + o_ff[15:0] + 16'(ffha_pkg::HDR_BYTES);
      n0       = end_ff + HDR_O + hm_ff;
      plow     = base_ff[15:0] + n0[15:0] + 16'(ffha_pkg::HDR_BYTES);
      pad16    = (16'd0 - plow) & amask_ff;
      stop_v   = n_ff + HDR_O + OW'(size_ff);
      lo_bound = {1'b0, base_ff} + 49'(ffha_pkg::HDR_BYTES);
      off48    = faddr_ff - base_ff - 48'(ffha_pkg::HDR_BYTES);
      pbv      = wd[ffha_pkg::LINK_W-1:0];

      if (csr_write_enable) begin
         unique case (csr_index)
            ffha_pkg::CSR_HEAP_BASE:  base_in  = csr_write_data & ~48'd7;
            ffha_pkg::CSR_HEAP_LIMIT: limit_in = csr_write_data[15:0];
            default: ;
         endcase
      end

      unique case (state_ff) inside
         ST_CLEAR: begin
            wr_req = 1'b1;
            wr_idx = OW'(clr_ff);
            wr_val = (clr_ff == AW'(1)) ? INIT_WORD : '0;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               func_in  = req_func;
               req_in   = req_request_bytes;
               rnd_in   = req_round_size;
               amask_in = 16'((17'd1 << al_eff) - 17'd1);
               size_in  = (17'(req_request_bytes) + 17'd7) & ~17'd7;
               faddr_in = req_free_address;
               end_in   = last_ff;
               state_in = ST_START;
            end
         end
         ST_START: begin
            o_in = '0;
            if (func_ff == ffha_pkg::FUNC_ALLOC) begin
               if (req_ff == 16'd0 || (!rnd_ff && req_ff[2:0] != 3'd0)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ffha_pkg::STATUS_BAD_SIZE;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_A_RD;
               end
            end else begin
               if ({1'b0, faddr_ff} < lo_bound || off48 > 48'(end_ff)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ffha_pkg::STATUS_NOT_IN_HEAP;
                  state_in      = ST_IDLE;
               end else if (off48[2:0] != 3'd0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ffha_pkg::STATUS_UNALIGNED;
                  state_in      = ST_IDLE;
               end else begin
                  off_in   = off48[OW-1:0];
                  state_in = ST_F_RD;
               end
            end
         end
         ST_A_RD: begin
            if (o_ff <= end_ff && o_ff < ARENA_LIM) begin
               rd_req   = 1'b1;
               rd_idx   = size_idx(o_ff);
               state_in = ST_A_DAT;
            end else begin
               state_in = ST_P_RD;
            end
         end
         ST_A_DAT, ST_P_DAT, ST_F_DAT, ST_C_DAT: begin
            hm_in = dmag;
            hf_in = wd[63];
            unique case (state_ff)
               ST_A_DAT: state_in = ST_A_EVAL;
               ST_P_DAT: state_in = ST_P_EVAL;
               ST_F_DAT: state_in = ST_F_EVAL;
               default:  state_in = ST_C_EVAL;
            endcase
         end
         ST_A_EVAL: begin
            if (hf_ff && hm_ff >= OW'(size_ff) && (alow & amask_ff) == 16'd0) begin
               if (hm_ff >= OW'(size_ff) + SPARE_O) begin
                  n_in     = o_ff + HDR_O + OW'(size_ff);
                  state_in = ST_S_W0;
               end else begin
                  wr_req        = 1'b1;
                  wr_idx        = size_idx(o_ff);
                  wr_val        = 64'(hm_ff);
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = base_ff + 48'(o_ff) + 48'(ffha_pkg::HDR_BYTES);
                  rsp_status_in = ffha_pkg::STATUS_OK;
                  state_in      = ST_IDLE;
               end
            end else begin
               o_in     = o_ff + HDR_O + hm_ff;
               state_in = ST_A_RD;
            end
         end
         ST_S_W0: begin
            wr_req   = 1'b1;
            wr_idx   = size_idx(n_ff);
            wr_val   = neg_word(hm_ff - OW'(size_ff) - HDR_O);
            state_in = ST_S_W1;
         end
         ST_S_W1: begin
            wr_req   = 1'b1;
            wr_idx   = n_ff >> 3;
            wr_val   = link_word(o_ff);
            state_in = ST_S_W2;
         end
         ST_S_W2: begin
            if (o_ff == end_ff) begin
               last_in = n_ff;
            end else begin
               wr_req = 1'b1;
               wr_idx = (o_ff + HDR_O + hm_ff) >> 3;
               wr_val = link_word(n_ff);
            end
            state_in = ST_S_W3;
         end
         ST_S_W3: begin
            wr_req        = 1'b1;
            wr_idx        = size_idx(o_ff);
            wr_val        = 64'(size_ff);
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = base_ff + 48'(o_ff) + 48'(ffha_pkg::HDR_BYTES);
            rsp_status_in = ffha_pkg::STATUS_OK;
            state_in      = ST_IDLE;
         end
         ST_P_RD: begin
            rd_req   = 1'b1;
            rd_idx   = size_idx(end_ff);
            state_in = ST_P_DAT;
         end
         ST_P_EVAL: begin
            pad_in   = OW'(pad16);
            n_in     = n0 + OW'(pad16);
            state_in = ST_P_CHK;
         end
         ST_P_CHK: begin
            stop_in = stop_v;
            if (stop_v > ARENA_LIM) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ffha_pkg::STATUS_OUT_OF_MEM;
               state_in      = ST_IDLE;
            end else if (stop_v > mapped_ff) begin
               newmap_in = mapped_ff;
               state_in  = ST_P_GROW;
            end else begin
               state_in = ST_P_W0;
            end
         end
         ST_P_GROW: begin
            if (newmap_ff >= stop_ff) begin
               if (newmap_ff > OW'(limit_ff)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ffha_pkg::STATUS_OUT_OF_MEM;
                  state_in      = ST_IDLE;
               end else begin
                  mapped_in = newmap_ff;
                  state_in  = ST_P_W0;
               end
            end else if (newmap_ff > OW'(limit_ff)) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ffha_pkg::STATUS_OUT_OF_MEM;
               state_in      = ST_IDLE;
            end else begin
               newmap_in = newmap_ff + PAGE_O;
            end
         end
         ST_P_W0: begin
            if (pad_ff != '0) begin
               wr_req = 1'b1;
               wr_idx = size_idx(end_ff);
               wr_val = hf_ff ? neg_word(hm_ff + pad_ff) : 64'(hm_ff + pad_ff);
            end
            state_in = ST_P_W1;
         end
         ST_P_W1: begin
            wr_req   = 1'b1;
            wr_idx   = size_idx(n_ff);
            wr_val   = 64'(size_ff);
            state_in = ST_P_W2;
         end
         ST_P_W2: begin
            wr_req        = 1'b1;
            wr_idx        = n_ff >> 3;
            wr_val        = link_word(end_ff);
            last_in       = n_ff;
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = base_ff + 48'(n_ff) + 48'(ffha_pkg::HDR_BYTES);
            rsp_status_in = ffha_pkg::STATUS_OK;
            state_in      = ST_IDLE;
         end
         ST_F_RD: begin
            if (o_ff <= end_ff && o_ff < ARENA_LIM) begin
               rd_req   = 1'b1;
               rd_idx   = size_idx(o_ff);
               state_in = ST_F_DAT;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ffha_pkg::STATUS_NOT_IN_HEAP;
               state_in      = ST_IDLE;
            end
         end
         ST_F_EVAL: begin
            if (o_ff == off_ff) begin
               if (hf_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = ffha_pkg::STATUS_DOUBLE_FREE;
                  state_in      = ST_IDLE;
               end else begin
                  wr_req   = 1'b1;
                  wr_idx   = size_idx(off_ff);
                  wr_val   = neg_word(hm_ff);
                  ns_in    = off_ff;
                  state_in = ST_B_RD;
               end
            end else begin
               o_in     = o_ff + HDR_O + hm_ff;
               state_in = ST_F_RD;
            end
         end
         ST_B_RD: begin
            rd_req   = 1'b1;
            rd_idx   = ns_ff >> 3;
            state_in = ST_B_DAT;
         end
         ST_B_DAT: begin
            if (!wd[ffha_pkg::LINK_VALID_BIT] || pbv >= 32'(ns_ff)) begin
               o_in     = ns_ff;
               state_in = ST_C_RD;
            end else begin
               o_in     = pbv[OW-1:0];
               state_in = ST_B_PRD;
            end
         end
         ST_B_PRD: begin
            rd_req   = 1'b1;
            rd_idx   = size_idx(o_ff);
            state_in = ST_B_PDAT;
         end
         ST_B_PDAT: begin
            if (wd[63]) begin
               ns_in    = o_ff;
               state_in = ST_B_RD;
            end else begin
               o_in     = ns_ff;
               state_in = ST_C_RD;
            end
         end
         ST_C_RD: begin
            if (o_ff <= end_ff && o_ff < ARENA_LIM) begin
               rd_req   = 1'b1;
               rd_idx   = size_idx(o_ff);
               state_in = ST_C_DAT;
            end else begin
               state_in = ST_M_W0;
            end
         end
         ST_C_EVAL: begin
            if (hf_ff) begin
               if (o_ff == end_ff) begin
                  last_in = ns_ff;
               end
               o_in     = o_ff + HDR_O + hm_ff;
               state_in = ST_C_RD;
            end else begin
               state_in = ST_M_W0;
            end
         end
         ST_M_W0: begin
            wr_req   = 1'b1;
            wr_idx   = size_idx(ns_ff);
            wr_val   = neg_word(o_ff - ns_ff - HDR_O);
            state_in = ST_M_W1;
         end
         ST_M_W1: begin
            if (o_ff <= last_ff) begin
               wr_req = 1'b1;
               wr_idx = o_ff >> 3;
               wr_val = link_word(ns_ff);
            end
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = '0;
            rsp_status_in = ffha_pkg::STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mem_re = rd_req && (rd_idx < WORDS_O);
   assign mem_we = wr_req && (wr_idx < WORDS_O);
   assign oor_in = rd_req ? !(rd_idx < WORDS_O) : oor_ff;

   ffha_arena_mem #(
      .DEPTH (ARENA_WORDS),
      .AW    (AW)
   ) u_arena (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_val),
      .rd_en   (mem_re),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         last_ff      <= '0;
         mapped_ff    <= PAGE_O;
         base_ff      <= '0;
         limit_ff     <= ffha_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         last_ff      <= last_in;
         mapped_ff    <= mapped_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      req_ff        <= req_in;
      rnd_ff        <= rnd_in;
      amask_ff      <= amask_in;
      size_ff       <= size_in;
      faddr_ff      <= faddr_in;
      end_ff        <= end_in;
      o_ff          <= o_in;
      off_ff        <= off_in;
      ns_ff         <= ns_in;
      hm_ff         <= hm_in;
      hf_ff         <= hf_in;
      n_ff          <= n_in;
      pad_ff        <= pad_in;
      stop_ff       <= stop_in;
      newmap_ff     <= newmap_in;
      oor_ff        <= oor_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ffha_pkg::STATUS_OK) |-> (rsp_payload_address == '0))
      else $error("failed transaction returned an address");

   assert property (@(posedge clock) disable iff (reset)
      !(mem_re && mem_we))
      else $error("arena read and write in the same cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while still working");

endmodule
